FILE: hw/rtl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types, constants and arithmetic helpers of the pedal load torque
// estimator.
// ----------------------------------------------------------------------------
package plt_pkg;

    // Default tuning values for the top-level parameters
    localparam int ACCEL_SHIFT_DEF   = 2;
    localparam int FREE_DEBOUNCE_DEF = 3;
    localparam int LOCK_DEBOUNCE_DEF = 2;
    localparam int ANCHOR_SHIFT_DEF  = 3;
    localparam int OUTPUT_SHIFT_DEF  = 2;
    localparam int ANCHOR_SETTLE_DEF = 4;

    // Fixed values
    localparam int CADENCE_MAX      = 2000;
    localparam int STEP_MAX         = 300;
    localparam int GAP_MIN_MS       = 10;
    localparam int GAP_MAX_MS       = 500;
    localparam int CRANK_SEEN_LEVEL = 10;
    localparam int SLEW_LIMIT       = 20;
    localparam int CONF3_MS         = 30000;
    localparam int CONF2_MS         = 120000;
    localparam int CONF1_MS         = 600000;
    localparam int AERO_COEF        = 37;
    localparam int FULL_PERCENT     = 100;
    localparam int CNT_MAX          = 255;

    // Rate divider: 1000 / elapsed
    localparam int DIVIDEND    = 1000;
    localparam int DIVIDEND_W  = 10;
    localparam int ELAPSED_W   = 9;
    localparam int QUOT_W      = 7;

    // Register reset values
    localparam int MCOEF_RST  = 220;
    localparam int ICOEF_RST  = 50;
    localparam int NBIAS_RST  = 20;
    localparam int FMARG_RST  = 100;
    localparam int LMARG_RST  = 50;
    localparam int MINCAD_RST = 100;
    localparam int SATPCT_RST = 95;
    localparam int MAXACC_RST = 2000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOTOR_COEF   = 3'd0,
        REG_INERTIA_COEF = 3'd1,
        REG_NOMINAL_BIAS = 3'd2,
        REG_FREE_MARGIN  = 3'd3,
        REG_LOCK_MARGIN  = 3'd4,
        REG_MIN_CADENCE  = 3'd5,
        REG_SAT_PERCENT  = 3'd6,
        REG_MAX_ACCEL    = 3'd7
    } plt_reg_t;

    // Controller to datapath
    typedef struct packed {
        logic idle;
        logic capture;
        logic check;
        logic div_start;
        logic accel;
        logic filt;
        logic torq;
        logic model;
        logic commit;
        logic smooth;
        logic load_out;
    } plt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip;
        logic div_done;
        logic out_free;
    } plt_stat_t;

    typedef logic signed [27:0] wide_t;

    // Divide by 2^k rounding toward zero
    function automatic wide_t div_pow2(wide_t x, int unsigned k);
        wide_t one;
        wide_t adj;
        one = wide_t'(1);
        adj = (x < 0) ? ((one <<< k) - one) : '0;
        return (x + adj) >>> k;
    endfunction

    function automatic wide_t clamp_sym(wide_t v, wide_t lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(wide_t v);
        if (v > wide_t'(32767)) return 16'sh7FFF;
        if (v < wide_t'(-32768)) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

FILE: hw/rtl/plt_if.sv
// ----------------------------------------------------------------------------
// plt_if
// Sample and result channels of the pedal load torque estimator.
// ----------------------------------------------------------------------------
interface plt_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] crank_cadence;
    logic [15:0] motor_cadence;
    logic [7:0]  current_percent;
    logic [31:0] time_ms;

    modport source (output valid, output crank_cadence, output motor_cadence,
                    output current_percent, output time_ms, input ready);
    modport sink   (input valid, input crank_cadence, input motor_cadence,
                    input current_percent, input time_ms, output ready);
endinterface

interface plt_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rider_torque;
    logic signed [15:0] load_bias;
    logic               is_locked;
    logic               is_anchored;
    logic               is_fresh;
    logic               is_valid;
    logic               is_saturated;
    logic [1:0]         confidence;
    logic               updated;

    modport source (output valid, output rider_torque, output load_bias,
                    output is_locked, output is_anchored, output is_fresh,
                    output is_valid, output is_saturated, output confidence,
                    output updated, input ready);
    modport sink   (input valid, input rider_torque, input load_bias,
                    input is_locked, input is_anchored, input is_fresh,
                    input is_valid, input is_saturated, input confidence,
                    input updated, output ready);
endinterface

FILE: hw/rtl/plt_div.sv
// ----------------------------------------------------------------------------
// plt_div
// Restoring divider, one quotient bit per cycle: 1000 / elapsed.
// ----------------------------------------------------------------------------
module plt_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [plt_pkg::ELAPSED_W-1:0] divisor,
    output logic                          done,
    output logic [plt_pkg::QUOT_W-1:0]    quotient
);
    import plt_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [ELAPSED_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ELAPSED_W:0]    trial;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = DIVIDEND_W'(DIVIDEND);
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = ELAPSED_W'(trial - {1'b0, divisor});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ELAPSED_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[QUOT_W-1:0];

endmodule

FILE: hw/rtl/plt_ctrl.sv
// ----------------------------------------------------------------------------
// plt_ctrl
// Sequencer: steps one sample through check, divide, accel, filter, torque,
// model, commit, smooth, result hand-off; a skip goes from check to hand-off.
// ----------------------------------------------------------------------------
module plt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  plt_pkg::plt_stat_t stat,
    output plt_pkg::plt_cmd_t  cmd
);
    import plt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_ACCEL,
        ST_FILT,
        ST_TORQ,
        ST_MODEL,
        ST_COMMIT,
        ST_SMOOTH,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_CHECK;
            ST_CHECK:  state_next = stat.skip ? ST_OUT : ST_DIV;
            ST_DIV:    if (stat.div_done) state_next = ST_ACCEL;
            ST_ACCEL:  state_next = ST_FILT;
            ST_FILT:   state_next = ST_TORQ;
            ST_TORQ:   state_next = ST_MODEL;
            ST_MODEL:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = ST_OUT;
            ST_OUT:    if (stat.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd           = '0;
        cmd.idle      = (state_reg == ST_IDLE);
        cmd.capture   = (state_reg == ST_IDLE) && in_valid;
        cmd.check     = (state_reg == ST_CHECK);
        cmd.div_start = (state_reg == ST_CHECK) && !stat.skip;
        cmd.accel     = (state_reg == ST_ACCEL);
        cmd.filt      = (state_reg == ST_FILT);
        cmd.torq      = (state_reg == ST_TORQ);
        cmd.model     = (state_reg == ST_MODEL);
        cmd.commit    = (state_reg == ST_COMMIT);
        cmd.smooth    = (state_reg == ST_SMOOTH);
        cmd.load_out  = (state_reg == ST_OUT) && stat.out_free;
    end

endmodule

FILE: hw/rtl/plt_dp.sv
// ----------------------------------------------------------------------------
// plt_dp
// Datapath: register file, estimator state, working registers, rate divider
// and the result register.
// ----------------------------------------------------------------------------
module plt_dp #(
    parameter int ACCEL_SHIFT   = plt_pkg::ACCEL_SHIFT_DEF,
    parameter int FREE_DEBOUNCE = plt_pkg::FREE_DEBOUNCE_DEF,
    parameter int LOCK_DEBOUNCE = plt_pkg::LOCK_DEBOUNCE_DEF,
    parameter int ANCHOR_SHIFT  = plt_pkg::ANCHOR_SHIFT_DEF,
    parameter int OUTPUT_SHIFT  = plt_pkg::OUTPUT_SHIFT_DEF,
    parameter int ANCHOR_SETTLE = plt_pkg::ANCHOR_SETTLE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  plt_pkg::plt_cmd_t              cmd,
    output plt_pkg::plt_stat_t             stat,
    input  logic                           wr_en,
    input  logic [plt_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [plt_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic [15:0]                    crank_cadence,
    input  logic [15:0]                    motor_cadence,
    input  logic [7:0]                     current_percent,
    input  logic [31:0]                    time_ms,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [15:0]             rider_torque,
    output logic signed [15:0]             load_bias,
    output logic [6:0]                     out_status,
    output logic                           updated
);
    import plt_pkg::*;

    // registers
    logic [10:0]        mcoef_reg, mcoef_next;
    logic [9:0]         icoef_reg, icoef_next;
    logic signed [11:0] nbias_reg, nbias_next;
    logic [10:0]        fmarg_reg, fmarg_next;
    logic [10:0]        lmarg_reg, lmarg_next;
    logic [10:0]        mincad_reg, mincad_next;
    logic [6:0]         satpct_reg, satpct_next;
    logic [14:0]        maxacc_reg, maxacc_next;

    // captured sample
    logic [15:0] crank_reg;
    logic [10:0] w_reg;
    logic [7:0]  pct_reg;
    logic [31:0] now_reg;

    // estimator state
    logic               have_prev_reg, have_prev_next;
    logic [31:0]        prev_time_reg, prev_time_next;
    logic [10:0]        prev_w_reg, prev_w_next;
    logic signed [15:0] facc_reg, facc_next;
    logic [15:0]        fcrank_reg, fcrank_next;
    logic               locked_reg, locked_next;
    logic [7:0]         free_cnt_reg, free_cnt_next;
    logic [7:0]         lock_cnt_reg, lock_cnt_next;
    logic [7:0]         run_cnt_reg, run_cnt_next;
    logic signed [15:0] bias_reg, bias_next;
    logic               anchored_reg, anchored_next;
    logic [31:0]        anchor_time_reg, anchor_time_next;
    logic               crank_seen_reg, crank_seen_next;
    logic signed [15:0] ts_reg, ts_next;
    logic [6:0]         status_reg, status_next;

    // working registers
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic signed [9:0]    dw_reg, dw_next;
    logic signed [15:0]   acc_reg, acc_next;
    logic [10:0]          gap_reg, gap_next;
    wide_t                tau_m_reg, tau_m_next;
    wide_t                tau_j_reg, tau_j_next;
    wide_t                tau_lim_reg, tau_lim_next;
    logic [11:0]          tt_reg, tt_next;
    wide_t                anchor_t_reg, anchor_t_next;
    wide_t                base_reg, base_next;
    logic                 anchor_ok_reg, anchor_ok_next;
    wide_t                taur_reg, taur_next;
    wide_t                fl_reg, fl_next;
    logic                 satchk_reg, satchk_next;
    logic [3:0]           flags_reg, flags_next;
    logic [1:0]           conf_reg, conf_next;
    logic                 upd_reg, upd_next;

    // result register
    logic               ovalid_reg, ovalid_next;
    logic signed [15:0] orider_reg, obias_reg;
    logic [6:0]         ostat_reg;
    logic               oupd_reg;

    // divider
    logic                 div_done;
    logic [QUOT_W-1:0]    quotient;

    plt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // combinational temporaries
    logic [31:0]        elapsed;
    logic               skip;
    logic signed [11:0] wdiff;
    logic signed [17:0] aprod;
    wide_t              fc1;
    wide_t              gap_w;
    logic               lock_t;
    logic [18:0]        pm;
    logic signed [25:0] pj;
    logic [17:0]        pl;
    logic [11:0]        wr16;
    logic [6:0]         tq;
    logic [14:0]        aero;
    logic [10:0]        terms;
    logic               valid_w;
    logic [31:0]        age;
    logic [31:0]        atime;
    logic               anch_n;
    wide_t              tr;
    logic               satd;

    assign elapsed = now_reg - prev_time_reg;
    assign skip    = !have_prev_reg || (elapsed < 32'(GAP_MIN_MS));
    assign valid_w = (w_reg >= mincad_reg);

    always_comb
    begin
        mcoef_next       = mcoef_reg;
        icoef_next       = icoef_reg;
        nbias_next       = nbias_reg;
        fmarg_next       = fmarg_reg;
        lmarg_next       = lmarg_reg;
        mincad_next      = mincad_reg;
        satpct_next      = satpct_reg;
        maxacc_next      = maxacc_reg;
        have_prev_next   = have_prev_reg;
        prev_time_next   = prev_time_reg;
        prev_w_next      = prev_w_reg;
        facc_next        = facc_reg;
        fcrank_next      = fcrank_reg;
        locked_next      = locked_reg;
        free_cnt_next    = free_cnt_reg;
        lock_cnt_next    = lock_cnt_reg;
        run_cnt_next     = run_cnt_reg;
        bias_next        = bias_reg;
        anchored_next    = anchored_reg;
        anchor_time_next = anchor_time_reg;
        crank_seen_next  = crank_seen_reg;
        ts_next          = ts_reg;
        status_next      = status_reg;
        elapsed_next     = elapsed_reg;
        dw_next          = dw_reg;
        acc_next         = acc_reg;
        gap_next         = gap_reg;
        tau_m_next       = tau_m_reg;
        tau_j_next       = tau_j_reg;
        tau_lim_next     = tau_lim_reg;
        tt_next          = tt_reg;
        anchor_t_next    = anchor_t_reg;
        base_next        = base_reg;
        anchor_ok_next   = anchor_ok_reg;
        taur_next        = taur_reg;
        fl_next          = fl_reg;
        satchk_next      = satchk_reg;
        flags_next       = flags_reg;
        conf_next        = conf_reg;
        upd_next         = upd_reg;
        wdiff = '0;
        aprod = '0;
        fc1   = '0;
        gap_w = '0;
        lock_t = 1'b0;
        pm    = '0;
        pj    = '0;
        pl    = '0;
        wr16  = '0;
        tq    = '0;
        aero  = '0;
        terms = '0;
        age   = '0;
        atime = anchor_time_reg;
        anch_n = anchored_reg;
        tr    = '0;
        satd  = 1'b0;

        if (wr_en)
        begin
            case (wr_index)
                REG_MOTOR_COEF:   mcoef_next  = wr_data[10:0];
                REG_INERTIA_COEF: icoef_next  = wr_data[9:0];
                REG_NOMINAL_BIAS:
                begin
                    nbias_next = wr_data[11:0];
                    if (!anchored_reg)
                        bias_next = 16'(signed'(wr_data[11:0]));
                end
                REG_FREE_MARGIN:  fmarg_next  = wr_data[10:0];
                REG_LOCK_MARGIN:  lmarg_next  = wr_data[10:0];
                REG_MIN_CADENCE:  mincad_next = wr_data[10:0];
                REG_SAT_PERCENT:  satpct_next = wr_data[6:0];
                REG_MAX_ACCEL:    maxacc_next = wr_data[14:0];
                default: ;
            endcase
        end

        // seed the crank filter, record first sample, latch interval
        if (cmd.check)
        begin
            if ((crank_reg > 16'(CRANK_SEEN_LEVEL)) && !crank_seen_reg)
            begin
                crank_seen_next = 1'b1;
                fcrank_next     = crank_reg;
            end
            upd_next = !skip;
            if (!have_prev_reg)
            begin
                have_prev_next = 1'b1;
                prev_time_next = now_reg;
                prev_w_next    = w_reg;
            end
            else if (!skip)
            begin
                prev_time_next = now_reg;
                prev_w_next    = w_reg;
                elapsed_next   = (elapsed > 32'(GAP_MAX_MS)) ? ELAPSED_W'(GAP_MAX_MS)
                                                             : elapsed[ELAPSED_W-1:0];
                wdiff   = signed'({1'b0, w_reg}) - signed'({1'b0, prev_w_reg});
                dw_next = 10'(clamp_sym(wide_t'(wdiff), wide_t'(STEP_MAX)));
            end
        end

        if (cmd.accel)
        begin
            aprod    = dw_reg * signed'({1'b0, quotient});
            acc_next = 16'(clamp_sym(wide_t'(aprod), wide_t'(maxacc_reg)));
        end

        // filters and clutch debounce
        if (cmd.filt)
        begin
            facc_next = 16'(wide_t'(facc_reg)
                          + div_pow2(wide_t'(acc_reg) - wide_t'(facc_reg), ACCEL_SHIFT));
            fc1 = wide_t'(fcrank_reg)
                + div_pow2(wide_t'(crank_reg) - wide_t'(fcrank_reg), 1);
            if (fc1 > wide_t'(w_reg))
                fc1 = wide_t'(w_reg);
            fcrank_next = fc1[15:0];
            gap_w    = wide_t'(w_reg) - fc1;
            gap_next = gap_w[10:0];
            lock_t   = locked_reg;
            if (locked_reg)
            begin
                if (gap_w[10:0] > fmarg_reg)
                begin
                    if (free_cnt_reg < 8'(CNT_MAX))
                        free_cnt_next = free_cnt_reg + 1'b1;
                end
                else
                    free_cnt_next = '0;
                if (free_cnt_next >= 8'(FREE_DEBOUNCE))
                begin
                    lock_t        = 1'b0;
                    lock_cnt_next = '0;
                end
            end
            else
            begin
                if (gap_w[10:0] < lmarg_reg)
                begin
                    if (lock_cnt_reg < 8'(CNT_MAX))
                        lock_cnt_next = lock_cnt_reg + 1'b1;
                end
                else
                    lock_cnt_next = '0;
                if (lock_cnt_next >= 8'(LOCK_DEBOUNCE))
                begin
                    lock_t        = 1'b1;
                    free_cnt_next = '0;
                end
            end
            locked_next = lock_t;
            if (!lock_t)
            begin
                if (run_cnt_reg < 8'(CNT_MAX))
                    run_cnt_next = run_cnt_reg + 1'b1;
            end
            else
                run_cnt_next = '0;
        end

        // products
        if (cmd.torq)
        begin
            pm           = mcoef_reg * pct_reg;
            tau_m_next   = wide_t'(pm[18:4]);
            pj           = signed'({1'b0, icoef_reg}) * facc_reg;
            tau_j_next   = wide_t'(pj >>> 4);
            pl           = mcoef_reg * 7'(FULL_PERCENT);
            tau_lim_next = wide_t'(pl[17:4]);
            wr16         = {1'b0, w_reg} + 12'd16;
            tq           = wr16[11:5];
            tt_next      = 12'(tq) * 12'(tq);
        end

        // load terms and anchor candidate
        if (cmd.model)
        begin
            aero  = tt_reg[11:3] * 6'(AERO_COEF);
            terms = {5'b0, w_reg[10:5]} + {1'b0, aero[14:5]};
            anchor_t_next = tau_m_reg - tau_j_reg - wide_t'(terms);
            base_next     = tau_j_reg + wide_t'(bias_reg) + wide_t'(terms);
            anchor_ok_next = crank_seen_reg && !locked_reg
                          && (run_cnt_reg >= 8'(ANCHOR_SETTLE))
                          && valid_w && (gap_reg >= fmarg_reg)
                          && (wide_t'(facc_reg) < wide_t'(maxacc_reg))
                          && (wide_t'(facc_reg) > -wide_t'(maxacc_reg));
        end

        // anchor, raw rider torque, confidence
        if (cmd.commit)
        begin
            if (anchor_ok_reg)
            begin
                if (!anchored_reg)
                    bias_next = sat16(anchor_t_reg);
                else
                    bias_next = sat16(wide_t'(bias_reg) + clamp_sym(
                        div_pow2(anchor_t_reg - wide_t'(bias_reg), ANCHOR_SHIFT),
                        wide_t'(SLEW_LIMIT)));
                anch_n = 1'b1;
                atime  = now_reg;
            end
            anchored_next    = anch_n;
            anchor_time_next = atime;
            if (!locked_reg || !valid_w)
                taur_next = '0;
            else
                taur_next = (base_reg - tau_m_reg < 0) ? '0 : base_reg - tau_m_reg;
            fl_next     = base_reg - tau_lim_reg;
            satchk_next = locked_reg && ({1'b0, pct_reg} >= {2'b0, satpct_reg}) && valid_w;
            age = now_reg - atime;
            conf_next = 2'd0;
            if (anch_n)
            begin
                if (age < 32'(CONF3_MS))      conf_next = 2'd3;
                else if (age < 32'(CONF2_MS)) conf_next = 2'd2;
                else if (age < 32'(CONF1_MS)) conf_next = 2'd1;
            end
            flags_next = {valid_w, (anch_n && (conf_next != 2'd0)), anch_n, locked_reg};
        end

        // motor-limit floor and output smoothing
        if (cmd.smooth)
        begin
            tr = taur_reg;
            if (satchk_reg && (fl_reg > taur_reg))
            begin
                tr   = taur_reg + div_pow2(fl_reg - taur_reg, 1);
                satd = 1'b1;
            end
            ts_next = sat16(wide_t'(ts_reg) + div_pow2(tr - wide_t'(ts_reg), OUTPUT_SHIFT));
            status_next = {conf_reg, satd, flags_reg};
        end
    end

    assign ovalid_next = cmd.load_out ? 1'b1 : (ovalid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcoef_reg       <= 11'(MCOEF_RST);
            icoef_reg       <= 10'(ICOEF_RST);
            nbias_reg       <= 12'(NBIAS_RST);
            fmarg_reg       <= 11'(FMARG_RST);
            lmarg_reg       <= 11'(LMARG_RST);
            mincad_reg      <= 11'(MINCAD_RST);
            satpct_reg      <= 7'(SATPCT_RST);
            maxacc_reg      <= 15'(MAXACC_RST);
            have_prev_reg   <= 1'b0;
            prev_time_reg   <= '0;
            prev_w_reg      <= '0;
            facc_reg        <= '0;
            fcrank_reg      <= '0;
            locked_reg      <= 1'b1;
            free_cnt_reg    <= '0;
            lock_cnt_reg    <= '0;
            run_cnt_reg     <= '0;
            bias_reg        <= 16'(NBIAS_RST);
            anchored_reg    <= 1'b0;
            anchor_time_reg <= '0;
            crank_seen_reg  <= 1'b0;
            ts_reg          <= '0;
            status_reg      <= '0;
            ovalid_reg      <= 1'b0;
        end
        else
        begin
            mcoef_reg       <= mcoef_next;
            icoef_reg       <= icoef_next;
            nbias_reg       <= nbias_next;
            fmarg_reg       <= fmarg_next;
            lmarg_reg       <= lmarg_next;
            mincad_reg      <= mincad_next;
            satpct_reg      <= satpct_next;
            maxacc_reg      <= maxacc_next;
            have_prev_reg   <= have_prev_next;
            prev_time_reg   <= prev_time_next;
            prev_w_reg      <= prev_w_next;
            facc_reg        <= facc_next;
            fcrank_reg      <= fcrank_next;
            locked_reg      <= locked_next;
            free_cnt_reg    <= free_cnt_next;
            lock_cnt_reg    <= lock_cnt_next;
            run_cnt_reg     <= run_cnt_next;
            bias_reg        <= bias_next;
            anchored_reg    <= anchored_next;
            anchor_time_reg <= anchor_time_next;
            crank_seen_reg  <= crank_seen_next;
            ts_reg          <= ts_next;
            status_reg      <= status_next;
            ovalid_reg      <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            crank_reg <= crank_cadence;
            w_reg     <= (motor_cadence > 16'(CADENCE_MAX)) ? 11'(CADENCE_MAX)
                                                            : motor_cadence[10:0];
            pct_reg   <= current_percent;
            now_reg   <= time_ms;
        end
        elapsed_reg   <= elapsed_next;
        dw_reg        <= dw_next;
        acc_reg       <= acc_next;
        gap_reg       <= gap_next;
        tau_m_reg     <= tau_m_next;
        tau_j_reg     <= tau_j_next;
        tau_lim_reg   <= tau_lim_next;
        tt_reg        <= tt_next;
        anchor_t_reg  <= anchor_t_next;
        base_reg      <= base_next;
        anchor_ok_reg <= anchor_ok_next;
        taur_reg      <= taur_next;
        fl_reg        <= fl_next;
        satchk_reg    <= satchk_next;
        flags_reg     <= flags_next;
        conf_reg      <= conf_next;
        upd_reg       <= upd_next;
        if (cmd.load_out)
        begin
            orider_reg <= ts_reg;
            obias_reg  <= bias_reg;
            ostat_reg  <= status_reg;
            oupd_reg   <= upd_reg;
        end
    end

    assign stat.skip     = skip;
    assign stat.div_done = div_done;
    assign stat.out_free = !ovalid_reg || out_ready;

    assign out_valid    = ovalid_reg;
    assign rider_torque = orider_reg;
    assign load_bias    = obias_reg;
    assign out_status   = ostat_reg;
    assign updated      = oupd_reg;

endmodule

FILE: hw/rtl/pedal_load_torque_estimator.sv
// ----------------------------------------------------------------------------
// pedal_load_torque_estimator
// Rider torque estimate from crank/motor cadence, motor current and time.
// ----------------------------------------------------------------------------
// One sample at a time. A sample that runs the estimator goes from acceptance
// through check, the one-bit-per-cycle 1000/dt divider (ten quotient steps
// plus the done strobe), 6 sequenced datapath steps, the load of the result
// register and back to idle, where the beat is offered and the next sample
// can be taken; a skipped sample (first after reset, or closer than 10 ms)
// goes through check, load and idle. A waiting result holds the block in its
// output state until the sink takes the beat.
// Config writes land in the register file at once; a nominal bias write also
// loads the bias while no anchor has been taken.
module pedal_load_torque_estimator #(
    parameter int ACCEL_SHIFT   = plt_pkg::ACCEL_SHIFT_DEF,
    parameter int FREE_DEBOUNCE = plt_pkg::FREE_DEBOUNCE_DEF,
    parameter int LOCK_DEBOUNCE = plt_pkg::LOCK_DEBOUNCE_DEF,
    parameter int ANCHOR_SHIFT  = plt_pkg::ANCHOR_SHIFT_DEF,
    parameter int OUTPUT_SHIFT  = plt_pkg::OUTPUT_SHIFT_DEF,
    parameter int ANCHOR_SETTLE = plt_pkg::ANCHOR_SETTLE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    plt_sample_if.sink                     sample,
    plt_result_if.source                   result,
    input  logic                           wr_en,
    input  logic [plt_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [plt_pkg::CFG_DATA_W-1:0] wr_data
);
    import plt_pkg::*;

    plt_cmd_t  cmd;
    plt_stat_t stat;
    logic [6:0] out_status;

    // sequencer
    plt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic, state and result register
    plt_dp #(
        .ACCEL_SHIFT   (ACCEL_SHIFT),
        .FREE_DEBOUNCE (FREE_DEBOUNCE),
        .LOCK_DEBOUNCE (LOCK_DEBOUNCE),
        .ANCHOR_SHIFT  (ANCHOR_SHIFT),
        .OUTPUT_SHIFT  (OUTPUT_SHIFT),
        .ANCHOR_SETTLE (ANCHOR_SETTLE)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .crank_cadence   (sample.crank_cadence),
        .motor_cadence   (sample.motor_cadence),
        .current_percent (sample.current_percent),
        .time_ms         (sample.time_ms),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .rider_torque    (result.rider_torque),
        .load_bias       (result.load_bias),
        .out_status      (out_status),
        .updated         (result.updated)
    );

    // sample beats are taken only in idle
    assign sample.ready = cmd.idle;

    // status word: locked, anchored, fresh, valid, saturated, confidence
    assign result.is_locked    = out_status[0];
    assign result.is_anchored  = out_status[1];
    assign result.is_fresh     = out_status[2];
    assign result.is_valid     = out_status[3];
    assign result.is_saturated = out_status[4];
    assign result.confidence   = out_status[6:5];

    // one sample in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("sample accepted while busy");

    // a result beat only appears from a result load
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.load_out))
        else $error("result valid without load");

    // result register never overwritten while a beat is pending
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result.valid || result.ready))
        else $error("pending result overwritten");

endmodule

FILE: test/plt_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_tb_if
// Testbench-side view of the estimator channels.
// ----------------------------------------------------------------------------
// The channel interfaces themselves come with the RTL (plt_sample_if and
// plt_result_if); this file only bundles the sink-side stall pattern control
// used by the receiver so the top level stays readable.
interface plt_stall_if;
    logic hold;
    logic [3:0] pattern;
endinterface

FILE: test/pedal_load_torque_estimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_load_torque_estimator_tb
// Self-checking bench for the pedal load torque estimator.
// ----------------------------------------------------------------------------
// A local predictor tracks the estimator state and configuration; every
// accepted sample queues one expected result, and each result beat is
// compared field by field with the oldest entry. Directed samples cover the
// skip rules, interval caps, clamps and extremes; random rides then drive the
// clutch through lock/freewheel cycles so anchors are taken.
module pedal_load_torque_estimator_tb;
    import plt_pkg::*;

    typedef struct packed {
        logic signed [15:0] rider_torque;
        logic signed [15:0] load_bias;
        logic               is_locked;
        logic               is_anchored;
        logic               is_fresh;
        logic               is_valid;
        logic               is_saturated;
        logic [1:0]         confidence;
        logic               updated;
    } torque_report_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    plt_sample_if sample ();
    plt_result_if result ();
    plt_stall_if  stall ();

    pedal_load_torque_estimator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample.sink),
        .result   (result.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // ---------------- predictor state ----------------
    int mcoef, icoef, nbias, fmarg, lmarg, mincad, satpct, maxacc;
    bit have_prev, locked, anchored, crank_on;
    int unsigned prev_t, anchor_t;
    int prev_w, f_accel, f_crank, bias, smooth;
    int unsigned free_cnt, lock_cnt, run_cnt;
    logic [7:0] status;

    torque_report_t expected_reports[$];
    int mismatches;
    int reports_checked;
    int anchors_seen;
    longint cycles;
    int unsigned clock_ms;    // running timestamp for generated samples

    function automatic int clip16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int floor16(int v);
        return v >>> 4;       // arithmetic shift is floor division
    endfunction

    function automatic int clip_sym(int v, int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    task automatic reset_predictor();
        mcoef = MCOEF_RST; icoef = ICOEF_RST; nbias = NBIAS_RST;
        fmarg = FMARG_RST; lmarg = LMARG_RST; mincad = MINCAD_RST;
        satpct = SATPCT_RST; maxacc = MAXACC_RST;
        have_prev = 0; prev_t = 0; prev_w = 0; f_accel = 0; f_crank = 0;
        locked = 1; free_cnt = 0; lock_cnt = 0; run_cnt = 0;
        bias = nbias; anchored = 0; anchor_t = 0; crank_on = 0;
        smooth = 0; status = '0;
    endtask

    task automatic apply_register(plt_reg_t idx, int unsigned val);
        int nb;
        case (idx)
            REG_MOTOR_COEF:   mcoef = val & 'h7FF;
            REG_INERTIA_COEF: icoef = val & 'h3FF;
            REG_NOMINAL_BIAS:
            begin
                nb = val & 'hFFF;
                if (nb & 'h800) nb -= 'h1000;
                nbias = nb;
                if (!anchored) bias = nb;
            end
            REG_FREE_MARGIN:  fmarg = val & 'h7FF;
            REG_LOCK_MARGIN:  lmarg = val & 'h7FF;
            REG_MIN_CADENCE:  mincad = val & 'h7FF;
            REG_SAT_PERCENT:  satpct = val & 'h7F;
            REG_MAX_ACCEL:    maxacc = val & 'h7FFF;
            default: ;
        endcase
    endtask

    function automatic torque_report_t held_report(bit ran);
        torque_report_t r;
        r.rider_torque = smooth[15:0];
        r.load_bias    = bias[15:0];
        r.is_locked    = status[0];
        r.is_anchored  = status[1];
        r.is_fresh     = status[2];
        r.is_valid     = status[3];
        r.is_saturated = status[4];
        r.confidence   = status[6:5];
        r.updated      = ran;
        return r;
    endfunction

    // Advances the estimator model by one sample and returns its report.
    task automatic estimate_torque(input logic [15:0] crank, input logic [15:0] motor,
                                   input logic [7:0] pct_in, input logic [31:0] now,
                                   output torque_report_t rep);
        int w, dw, accel, gap, tau_m, tau_j, terms, tau_load, tau_r, t, fl, pct;
        int unsigned elapsed, age, conf;
        logic [7:0] flags;
        bit freewheel;
        pct = pct_in;
        if (crank > CRANK_SEEN_LEVEL && !crank_on)
        begin
            crank_on = 1;
            f_crank = crank;
        end
        w = (motor > CADENCE_MAX) ? CADENCE_MAX : int'(motor);
        if (!have_prev)
        begin
            prev_t = now; prev_w = w; have_prev = 1;
            rep = held_report(0);
            return;
        end
        elapsed = now - prev_t;
        if (elapsed < GAP_MIN_MS)
        begin
            rep = held_report(0);
            return;
        end
        if (elapsed > GAP_MAX_MS) elapsed = GAP_MAX_MS;
        prev_t = now;

        dw = clip_sym(w - prev_w, STEP_MAX);
        prev_w = w;
        accel = clip_sym(dw * int'(1000 / elapsed), maxacc);
        f_accel += (accel - f_accel) / (1 << ACCEL_SHIFT_DEF);

        f_crank += (int'(crank) - f_crank) / 2;
        if (f_crank > w) f_crank = w;
        gap = w - f_crank;
        if (locked)
        begin
            if (gap > fmarg) begin if (free_cnt < CNT_MAX) free_cnt++; end
            else free_cnt = 0;
            if (free_cnt >= FREE_DEBOUNCE_DEF) begin locked = 0; lock_cnt = 0; end
        end
        else
        begin
            if (gap < lmarg) begin if (lock_cnt < CNT_MAX) lock_cnt++; end
            else lock_cnt = 0;
            if (lock_cnt >= LOCK_DEBOUNCE_DEF) begin locked = 1; free_cnt = 0; end
        end
        freewheel = !locked;
        if (freewheel) begin if (run_cnt < CNT_MAX) run_cnt++; end
        else run_cnt = 0;

        tau_m = floor16(mcoef * pct);
        tau_j = floor16(icoef * f_accel);
        t = (w + 16) / 32;
        terms = (8 * w) / 256 + (((t * t) / 8) * AERO_COEF) / 32;
        tau_load = bias + terms;

        if (crank_on && freewheel && run_cnt >= ANCHOR_SETTLE_DEF && w >= mincad &&
            gap >= fmarg && f_accel < maxacc && f_accel > -maxacc)
        begin
            t = tau_m - tau_j - terms;
            if (!anchored)
            begin
                bias = clip16(t);
                anchored = 1;
            end
            else
            begin
                t = clip_sym((t - bias) / (1 << ANCHOR_SHIFT_DEF), SLEW_LIMIT);
                bias = clip16(bias + t);
            end
            anchor_t = now;
            anchors_seen++;
        end

        if (freewheel) tau_r = 0;
        else
        begin
            tau_r = tau_j + tau_load - tau_m;
            if (tau_r < 0) tau_r = 0;
        end
        flags = 0;
        if (locked) flags |= 1;
        conf = 0;
        if (anchored)
        begin
            flags |= 2;
            age = now - anchor_t;
            if (age < CONF3_MS) conf = 3;
            else if (age < CONF2_MS) conf = 2;
            else if (age < CONF1_MS) conf = 1;
            if (conf > 0) flags |= 4;
        end
        if (w < mincad) tau_r = 0;
        else flags |= 8;
        if (locked && pct >= satpct && flags[3])
        begin
            fl = tau_j + tau_load - floor16(mcoef * FULL_PERCENT);
            if (fl > tau_r)
            begin
                tau_r += (fl - tau_r) / 2;
                flags |= 16;
            end
        end
        flags |= conf << 5;
        status = flags;
        smooth = clip16(smooth + (tau_r - smooth) / (1 << OUTPUT_SHIFT_DEF));
        rep = held_report(1);
    endtask

    // ---------------- clock, limit ----------------
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ---------------- receiver ----------------
    // Stalls on a rotating pattern; a long hold-off forces the block to back up.
    int long_hold;
    initial
    begin
        result.ready = 0;
        long_hold = 0;
        stall.pattern = 4'b1011;
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                long_hold--;
                result.ready <= 0;
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    stall.pattern <= 4'($urandom());
                else
                    stall.pattern <= {stall.pattern[2:0], stall.pattern[3]};
                result.ready <= stall.hold ? 1'b1 : (stall.pattern[0] | ($urandom_range(0, 3) == 0));
            end
        end
    end

    // ---------------- result checker ----------------
    initial
    begin
        torque_report_t got, want;
        mismatches = 0;
        reports_checked = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result.valid && result.ready)
            begin
                got.rider_torque = result.rider_torque;
                got.load_bias    = result.load_bias;
                got.is_locked    = result.is_locked;
                got.is_anchored  = result.is_anchored;
                got.is_fresh     = result.is_fresh;
                got.is_valid     = result.is_valid;
                got.is_saturated = result.is_saturated;
                got.confidence   = result.confidence;
                got.updated      = result.updated;
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result beat: %p", got);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    reports_checked++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result %0d differs\n  expected %p\n  actual   %p",
                                     reports_checked, want, got);
                    end
                end
            end
        end
    end

    // ---------------- sender ----------------
    int burst_left;

    // Offers one sample, waits for the beat, then queues its prediction.
    // Valid stays high across a burst; it drops only for a gap or a drain.
    task automatic send_sample(logic [15:0] crank, logic [15:0] motor,
                               logic [7:0] pct, logic [31:0] now);
        torque_report_t rep;
        int gap_cycles;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap_cycles = $urandom_range(0, 1) ? $urandom_range(1, 30) : 0;
            if (gap_cycles > 0)
            begin
                sample.valid <= 0;
                repeat (gap_cycles) @(posedge clk);
            end
        end
        burst_left--;
        sample.valid <= 1;
        sample.crank_cadence <= crank;
        sample.motor_cadence <= motor;
        sample.current_percent <= pct;
        sample.time_ms <= now;
        do @(posedge clk); while (!sample.ready);
        estimate_torque(crank, motor, pct, now, rep);
        expected_reports.push_back(rep);
    endtask

    task automatic drain();
        sample.valid <= 0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_register(plt_reg_t idx, int unsigned val);
        @(posedge clk);
        wr_en <= 1;
        wr_index <= idx;
        wr_data <= CFG_DATA_W'(val);
        @(posedge clk);
        wr_en <= 0;
        apply_register(idx, val & ((1 << CFG_DATA_W) - 1));
    endtask

    // Pedaling sample: motor and crank close together, clutch engaged.
    task automatic send_pedaling(int cad, int step_ms);
        clock_ms += step_ms;
        send_sample(16'(cad + $urandom_range(0, 20)), 16'(cad), 8'($urandom_range(0, 110)),
                    clock_ms);
    endtask

    // Coasting sample: crank drops, motor keeps turning, clutch opens.
    task automatic send_coasting(int cad, int step_ms);
        clock_ms += step_ms;
        send_sample(16'($urandom_range(0, 40)), 16'(cad), 8'($urandom_range(0, 60)), clock_ms);
    endtask

    // Skip rules, interval limits, field extremes and clamps.
    task automatic test_directed();
        send_sample(16'd500, 16'd800, 8'd50, 32'd1000);      // first: records only
        send_sample(16'd500, 16'd800, 8'd50, 32'd1005);      // too soon
        send_sample(16'd500, 16'd800, 8'd50, 32'd1010);      // exactly 10 ms
        send_sample(16'd500, 16'd1900, 8'd50, 32'd1020);     // step clamp
        send_sample(16'd0, 16'hFFFF, 8'hFF, 32'd1030);       // cadence clamp, max pct
        send_sample(16'hFFFF, 16'd0, 8'd0, 32'd1031);        // under gap
        send_sample(16'hFFFF, 16'd0, 8'd0, 32'd5000);        // long gap cap
        send_sample(16'd0, 16'd2000, 8'd100, 32'hFFFF_FFF0); // wrap forward
        send_sample(16'd0, 16'd2000, 8'd100, 32'd4);         // across wrap
        send_sample(16'd0, 16'd2000, 8'd95, 32'd300);
        send_sample(16'd0, 16'd2000, 8'd96, 32'd799);
        send_sample(16'd10, 16'd50, 8'd0, 32'd1299);
        send_sample(16'd0, 16'd1500, 8'd255, 32'd1310);
        send_sample(16'd0, 16'd1500, 8'd255, 32'd1800);
        send_sample(16'd0, 16'd1500, 8'd120, 32'd2300);
        send_sample(16'hAAAA, 16'h5555, 8'hAA, 32'hAAAA_AAAA);
        send_sample(16'h5555, 16'hAAAA, 8'h55, 32'h5555_5555);
        clock_ms = 32'h5555_5555;
        drain();
    endtask

    // A ride: pedaling stretches and coasts, so anchors get taken and aged.
    task automatic test_rides(int n);
        int cad, k;
        repeat (n)
        begin
            cad = $urandom_range(50, 2000);
            for (k = $urandom_range(2, 10); k > 0; k--)
            begin
                cad = clip_sym(cad + $urandom_range(0, 200) - 100, 2000);
                if (cad < 0) cad = 0;
                send_pedaling(cad, $urandom_range(5, 120));
            end
            for (k = $urandom_range(3, 12); k > 0; k--)
                send_coasting(cad, $urandom_range(5, 150));
            if ($urandom_range(0, 9) == 0) clock_ms += $urandom_range(30000, 700000);
        end
    endtask

    // Noise: unconstrained fields.
    task automatic test_noise(int n);
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
            else clock_ms += $urandom_range(0, 600);
            send_sample(16'($urandom()), 16'($urandom()), 8'($urandom()), clock_ms);
        end
    endtask

    // Back-pressure: the receiver holds off while samples keep coming.
    task automatic test_backpressure();
        long_hold = 400;
        test_rides(4);
    endtask

    task automatic test_register_settings();
        drain();
        write_register(REG_MOTOR_COEF, 2047);
        write_register(REG_INERTIA_COEF, 1023);
        write_register(REG_NOMINAL_BIAS, 12'(-2000));
        write_register(REG_FREE_MARGIN, 0);
        write_register(REG_LOCK_MARGIN, 2000);
        write_register(REG_MIN_CADENCE, 0);
        write_register(REG_SAT_PERCENT, 0);
        write_register(REG_MAX_ACCEL, 30000);
        test_rides(20);
        drain();
        write_register(REG_MOTOR_COEF, 0);
        write_register(REG_INERTIA_COEF, 0);
        write_register(REG_NOMINAL_BIAS, 2000);
        write_register(REG_FREE_MARGIN, 2000);
        write_register(REG_LOCK_MARGIN, 0);
        write_register(REG_MIN_CADENCE, 2000);
        write_register(REG_SAT_PERCENT, 100);
        write_register(REG_MAX_ACCEL, 0);
        test_rides(10);
        drain();
        write_register(REG_MOTOR_COEF, 220);
        write_register(REG_INERTIA_COEF, 50);
        write_register(REG_NOMINAL_BIAS, 20);
        write_register(REG_FREE_MARGIN, 100);
        write_register(REG_LOCK_MARGIN, 50);
        write_register(REG_MIN_CADENCE, 100);
        write_register(REG_SAT_PERCENT, 95);
        write_register(REG_MAX_ACCEL, 2000);
        write_register(REG_MAX_ACCEL, 'h7FFF);   // all data bits high
        drain();
        write_register(REG_MAX_ACCEL, 2000);
    endtask

    initial
    begin
        rst_n = 0;
        wr_en = 0;
        wr_index = '0;
        wr_data = '0;
        sample.valid = 0;
        sample.crank_cadence = '0;
        sample.motor_cadence = '0;
        sample.current_percent = '0;
        sample.time_ms = '0;
        stall.hold = 0;
        burst_left = 0;
        anchors_seen = 0;
        clock_ms = 0;
        reset_predictor();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        test_directed();
        test_rides(30);
        test_backpressure();
        test_noise(250);
        test_register_settings();
        stall.hold = 1;
        test_rides(20);
        stall.hold = 0;
        test_rides(20);
        drain();

        $display("Checked %0d result beats; %0d load anchors taken across clutch cycles",
                 reports_checked, anchors_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
